### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the idle sleep decider.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg
// Types, codes and reset values shared by the idle sleep decider modules.
// ----------------------------------------------------------------------------
package isd_pkg;

    // Width of the timestamp field on the request port.
    localparam int NOW_BITS = 48;
    // Default width of the internal time arithmetic.
    localparam int TIME_BITS_DEF = 48;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
    localparam logic [6:0]  BATTERY_MAX   = 7'd100;

    // Command codes.
    localparam logic [2:0] CMD_ACTIVITY = 3'd0;
    localparam logic [2:0] CMD_CHARGE   = 3'd1;
    localparam logic [2:0] CMD_BOUND    = 3'd2;
    localparam logic [2:0] CMD_UNBOUND  = 3'd3;
    localparam logic [2:0] CMD_BATTERY  = 3'd4;
    localparam logic [2:0] CMD_TICK     = 3'd5;
    localparam logic [2:0] CMD_DISABLE  = 3'd6;

    // Action codes.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SLEEP   = 2'd1;
    localparam logic [1:0] ACT_REFUSED = 2'd2;

    // Register indexes.
    typedef enum logic [1:0] {
        REG_AUTO_SLEEP   = 2'd0,
        REG_IDLE_MINUTES = 2'd1,
        REG_GRACE_MS     = 2'd2,
        REG_LOW_BATTERY  = 2'd3
    } t_reg_idx;

    // Register reset values.
    localparam logic        RST_AUTO_SLEEP   = 1'b1;
    localparam logic [15:0] RST_IDLE_MINUTES = 16'd5;
    localparam logic [31:0] RST_IDLE_MS      = 32'd300000;
    localparam logic [31:0] RST_GRACE_MS     = 32'd7200000;
    localparam logic [6:0]  RST_LOW_BATTERY  = 7'd20;

    typedef struct packed {
        logic [2:0]          command;
        logic [NOW_BITS-1:0] now_ms;
        logic                charge_present;
        logic signed [15:0]  battery_raw;
        logic                sleep_blocked;
        logic                ext_power;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic       unbound_started;
    } t_out_item;

    // Policy settings handed from the register file to the decision logic.
    typedef struct packed {
        logic        auto_sleep_enable;
        logic [31:0] idle_threshold_ms;
        logic [31:0] grace_window_ms;
        logic [6:0]  low_battery_percent;
    } t_cfg;

endpackage

### hw/rtl/isd_regs.sv
// ----------------------------------------------------------------------------
// isd_regs
// APB register file for the sleep policy; also keeps the idle timeout scaled
// to milliseconds.
// ----------------------------------------------------------------------------
module isd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [isd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [isd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output isd_pkg::t_cfg                     o_cfg
);
    import isd_pkg::*;

    logic        r_auto_sleep;
    logic [15:0] r_idle_minutes;
    logic [31:0] r_idle_ms;
    logic [31:0] r_grace_ms;
    logic [6:0]  r_low_battery;
    logic        w_write;
    t_reg_idx    w_idx;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_idx   = t_reg_idx'(paddr[3:2]);

    // Register writes; the millisecond threshold is formed once per write of the idle minutes register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_sleep   <= RST_AUTO_SLEEP;
            r_idle_minutes <= RST_IDLE_MINUTES;
            r_idle_ms      <= RST_IDLE_MS;
            r_grace_ms     <= RST_GRACE_MS;
            r_low_battery  <= RST_LOW_BATTERY;
        end else if (w_write) begin
            case (w_idx)
                REG_AUTO_SLEEP: begin
                    r_auto_sleep <= pwdata[0];
                end
                REG_IDLE_MINUTES: begin
                    r_idle_minutes <= pwdata[15:0];
                    r_idle_ms      <= 32'({16'd0, pwdata[15:0]} * MS_PER_MINUTE);
                end
                REG_GRACE_MS: begin
                    r_grace_ms <= pwdata;
                end
                REG_LOW_BATTERY: begin
                    r_low_battery <= pwdata[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (w_idx)
            REG_AUTO_SLEEP:   prdata = {31'd0, r_auto_sleep};
            REG_IDLE_MINUTES: prdata = {16'd0, r_idle_minutes};
            REG_GRACE_MS:     prdata = r_grace_ms;
            REG_LOW_BATTERY:  prdata = {25'd0, r_low_battery};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.auto_sleep_enable   = r_auto_sleep;
    assign o_cfg.idle_threshold_ms   = r_idle_ms;
    assign o_cfg.grace_window_ms     = r_grace_ms;
    assign o_cfg.low_battery_percent = r_low_battery;

endmodule

### hw/rtl/idle_sleep_decider.sv
// ----------------------------------------------------------------------------
// idle_sleep_decider
// Event-driven policy that decides when an idle device requests deep sleep.
// ----------------------------------------------------------------------------
// Each request is one timestamped event and produces exactly one result. It
// passes an input register, compare and subtract logic against the policy
// state, then a result register. A new request is taken every cycle,
// including while a finished result waits on a stalled output, as long as the
// input register is free to move on. The idle timeout is scaled to
// milliseconds when its register is written, so a tick only needs two
// subtract-and-compare paths of TIME_BITS bits.
`include "assert_macros.svh"

module idle_sleep_decider #(
    parameter int TIME_BITS = isd_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  isd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output isd_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [isd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [isd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import isd_pkg::*;

    t_cfg                 w_cfg;

    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [TIME_BITS-1:0] r_last_active;
    logic                 r_paused_by_charge;
    logic                 r_unbound_flag;
    logic [TIME_BITS-1:0] r_unbound_since;
    logic [6:0]           r_battery;
    logic                 r_disabled_latch;

    logic [TIME_BITS-1:0] n_last_active;
    logic                 n_paused_by_charge;
    logic                 n_unbound_flag;
    logic [TIME_BITS-1:0] n_unbound_since;
    logic [6:0]           n_battery;
    logic                 n_disabled_latch;
    t_out_item            n_out;

    logic                 w_advance;
    logic                 w_done;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_idle_diff;
    logic [TIME_BITS-1:0] w_since_diff;
    logic                 w_idle_reached;
    logic                 w_grace;
    logic                 w_try_sleep;
    logic [6:0]           w_battery_clamped;

    isd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The result register can take a new result when empty or being drained.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_done     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Time compares shared by the tick decision.
    assign w_now          = TIME_BITS'(r_in.now_ms);
    assign w_idle_diff    = w_now - r_last_active;
    assign w_since_diff   = w_now - r_unbound_since;
    assign w_idle_reached = (w_now >= r_last_active)
                         && (w_idle_diff >= TIME_BITS'(w_cfg.idle_threshold_ms));
    assign w_grace        = r_unbound_flag
                         && !(r_battery < w_cfg.low_battery_percent)
                         && ((w_now < r_unbound_since)
                          || (w_since_diff < TIME_BITS'(w_cfg.grace_window_ms)));
    assign w_try_sleep    = w_cfg.auto_sleep_enable && !r_disabled_latch
                         && !r_paused_by_charge && !r_in.sleep_blocked
                         && !w_grace && w_idle_reached;

    // Battery report clamped to the percent range.
    always_comb begin
        if (r_in.battery_raw < 16'sd0) begin
            w_battery_clamped = 7'd0;
        end else if (r_in.battery_raw > 16'sd100) begin
            w_battery_clamped = BATTERY_MAX;
        end else begin
            w_battery_clamped = r_in.battery_raw[6:0];
        end
    end

    // Event decode: next policy state and the result.
    always_comb begin
        n_last_active      = r_last_active;
        n_paused_by_charge = r_paused_by_charge;
        n_unbound_flag     = r_unbound_flag;
        n_unbound_since    = r_unbound_since;
        n_battery          = r_battery;
        n_disabled_latch   = r_disabled_latch;
        n_out.action          = ACT_NONE;
        n_out.unbound_started = 1'b0;
        case (r_in.command)
            CMD_ACTIVITY: begin
                n_last_active = w_now;
            end
            CMD_CHARGE: begin
                n_paused_by_charge = r_in.charge_present;
                if (r_in.charge_present) begin
                    n_last_active = w_now;
                end
            end
            CMD_BOUND: begin
                n_unbound_flag  = 1'b0;
                n_unbound_since = '0;
            end
            CMD_UNBOUND: begin
                if (!r_unbound_flag) begin
                    n_unbound_flag        = 1'b1;
                    n_unbound_since       = w_now;
                    n_out.unbound_started = 1'b1;
                end
            end
            CMD_BATTERY: begin
                n_battery = w_battery_clamped;
            end
            CMD_TICK: begin
                if (w_try_sleep) begin
                    if (r_in.ext_power) begin
                        // External power: refuse and treat as activity.
                        n_paused_by_charge = 1'b1;
                        n_last_active      = w_now;
                        n_out.action       = ACT_REFUSED;
                    end else begin
                        n_out.action = ACT_SLEEP;
                    end
                end
            end
            CMD_DISABLE: begin
                n_disabled_latch = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Policy state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_active      <= '0;
            r_paused_by_charge <= 1'b0;
            r_unbound_flag     <= 1'b0;
            r_unbound_since    <= '0;
            r_battery          <= '0;
            r_disabled_latch   <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_done) begin
                r_last_active      <= n_last_active;
                r_paused_by_charge <= n_paused_by_charge;
                r_unbound_flag     <= n_unbound_flag;
                r_unbound_since    <= n_unbound_since;
                r_battery          <= n_battery;
                r_disabled_latch   <= n_disabled_latch;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (w_done) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A refused tick leaves the charge pause set.
    `ASSERT_NEXT(a_refuse_pauses, i_clk, i_rst_n, w_done && (n_out.action == ACT_REFUSED), r_paused_by_charge, "refused tick did not set pause")
    // A sleep request only leaves while the policy allows sleep.
    `ASSERT_IMPLIES(a_sleep_allowed, i_clk, i_rst_n, r_out_valid && (r_out.action == ACT_SLEEP), w_cfg.auto_sleep_enable && !r_disabled_latch, "sleep requested while disabled")
    // A new grace period leaves the unbound flag set.
    `ASSERT_IMPLIES(a_unbound_flag, i_clk, i_rst_n, r_out_valid && r_out.unbound_started, r_unbound_flag, "unbound start without flag")
    // The input side only stalls while holding a request.
    `ASSERT_IMPLIES(a_stall_holds, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "input stall without a held request")

endmodule
